/* hdl/pcgdm_pkg.sv */
// Package for the PCG32 dropout mask engine: widths, register indexes,
// generator constants and the 64-bit multiply by the PCG multiplier.
// Depends on nothing; used by pcg32_dropout_mask.
package pcgdm_pkg;

  localparam int VALUE_WIDTH = 16;

  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_WIDTH + 32 + 7) / 8) * 8;
  localparam int PROD_W      = VALUE_WIDTH + 17;
  localparam int SHIFT_W     = PROD_W - 12;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] CFG_SEED      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STREAM    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE     = 2'd3;

  localparam logic [63:0] PCG_MULT     = 64'd6364136223846793005;
  localparam logic [31:0] PCG_MULT_LO  = PCG_MULT[31:0];
  localparam logic [31:0] PCG_MULT_HI  = PCG_MULT[63:32];
  localparam logic [63:0] RESET_SEED   = 64'h853c49e6748fea9b;
  localparam logic [62:0] RESET_STREAM = 63'h5a3e39cb94b95bdb;
  localparam logic [15:0] RESET_THRESH = 16'hFFFF;
  localparam logic [15:0] RESET_SCALE  = 16'd4096;

  // Low 64 bits of a times the PCG multiplier, built from 32-bit partial products.
  function automatic logic [63:0] mul_pcg(input logic [63:0] a);
    logic [63:0] lo;
    logic [31:0] cross_a;
    logic [31:0] cross_b;
    lo      = {32'd0, a[31:0]} * {32'd0, PCG_MULT_LO};
    cross_a = a[63:32] * PCG_MULT_LO;
    cross_b = a[31:0] * PCG_MULT_HI;
    return lo + {cross_a + cross_b, 32'd0};
  endfunction

  // Generator state right after a reseed: clear, step, add seed, step.
  function automatic logic [63:0] reseed_state(input logic [63:0] seed,
                                               input logic [63:0] incr);
    logic [63:0] s;
    s = incr;
    s = s + seed;
    return mul_pcg(s) + incr;
  endfunction

  localparam logic [63:0] RESET_GEN_STATE = reseed_state(RESET_SEED, {RESET_STREAM, 1'b1});

endpackage

/* hdl/pcg32_dropout_mask.sv */
// Dropout mask engine on a PCG32 XSH-RR generator with Q4.12 rescaling of kept values.
// An accepted input beat is registered in stage one, then in the output stage; throughput
// one beat per cycle unless the output is back-pressured. A write to seed or stream_select
// stalls input during the reseed recompute on the shared 64-bit generator multiplier.
// Reset (rst_n low, synchronous) loads the register reset values and a seeded generator.
// Depends on pcgdm_pkg.
module pcg32_dropout_mask (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pcgdm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pcgdm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pcgdm_pkg::IN_TDATA_W-1:0]      in_tdata,   // sample_value
  input  logic [0:0]                            in_tuser,   // restart
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pcgdm_pkg::OUT_TDATA_W-1:0]     out_tdata,  // scaled_value, random_word
  output logic [0:0]                            out_tuser   // keep
);

  localparam int VW = pcgdm_pkg::VALUE_WIDTH;

  typedef enum logic [1:0] {PH_IDLE, PH_SUM, PH_MUL} phase_t;

  phase_t phase_r;
  logic [63:0] seed_r;
  logic [62:0] stream_r;
  logic [15:0] thresh_r;
  logic [15:0] scale_r;
  logic [63:0] gen_state_r;
  logic [63:0] reseed_r;
  logic [63:0] sum_r;

  logic          valid1_r;
  logic [63:0]   old1_r;
  logic [VW-1:0] sample1_r;

  logic          out_valid_r;
  logic          keep_r;
  logic [VW-1:0] scaled_r;
  logic [31:0]   word_r;

  logic [63:0] incr;
  logic [63:0] old_sel;
  logic [63:0] mul_in;
  logic [63:0] mul_out;
  logic        adv_out;
  logic        adv1;
  logic        in_accept;

  assign incr    = {stream_r, 1'b1};
  assign old_sel = in_tuser[0] ? reseed_r : gen_state_r;
  assign mul_in  = (phase_r == PH_MUL) ? sum_r : old_sel;
  assign mul_out = pcgdm_pkg::mul_pcg(mul_in) + incr;

  assign adv_out   = !out_valid_r || out_tready;
  assign adv1      = !valid1_r || adv_out;
  assign in_tready = (phase_r == PH_IDLE) && adv1;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= pcgdm_pkg::RESET_SEED;
      stream_r <= pcgdm_pkg::RESET_STREAM;
      thresh_r <= pcgdm_pkg::RESET_THRESH;
      scale_r  <= pcgdm_pkg::RESET_SCALE;
    end else if (cfg_we) begin
      case (cfg_addr)
        pcgdm_pkg::CFG_SEED:      seed_r   <= cfg_wdata;
        pcgdm_pkg::CFG_STREAM:    stream_r <= cfg_wdata[62:0];
        pcgdm_pkg::CFG_THRESHOLD: thresh_r <= cfg_wdata[15:0];
        pcgdm_pkg::CFG_SCALE:     scale_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Reseed sequencer: recomputes the post-restart state after seed or stream writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      reseed_r <= pcgdm_pkg::RESET_GEN_STATE;
    end else if (cfg_we && (cfg_addr == pcgdm_pkg::CFG_SEED ||
                            cfg_addr == pcgdm_pkg::CFG_STREAM)) begin
      phase_r <= PH_SUM;
    end else begin
      case (phase_r)
        PH_SUM: begin
          sum_r   <= seed_r + incr;
          phase_r <= PH_MUL;
        end
        PH_MUL: begin
          reseed_r <= mul_out;
          phase_r  <= PH_IDLE;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_state_r <= pcgdm_pkg::RESET_GEN_STATE;
    end else if (in_accept) begin
      gen_state_r <= mul_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (adv1) begin
      valid1_r <= in_accept;
    end
    if (in_accept) begin
      old1_r    <= old_sel;
      sample1_r <= in_tdata[VW-1:0];
    end
  end

  logic [63:0]                        mix;
  logic [31:0]                        xs;
  logic [4:0]                         rot;
  logic [63:0]                        xs2;
  logic [31:0]                        word;
  logic                               keep;
  logic signed [pcgdm_pkg::PROD_W-1:0]  prod;
  logic signed [pcgdm_pkg::SHIFT_W-1:0] shifted;
  logic [pcgdm_pkg::SHIFT_W-VW:0]       top;
  logic [VW-1:0]                      sat;

  assign mix     = old1_r ^ (old1_r >> 18);
  assign xs      = mix[58:27];
  assign rot     = old1_r[63:59];
  assign xs2     = {xs, xs} >> rot;
  assign word    = xs2[31:0];
  assign keep    = word[15:0] < thresh_r;
  assign prod    = $signed(sample1_r) * $signed({1'b0, scale_r});
  assign shifted = prod[pcgdm_pkg::PROD_W-1:12];
  assign top     = shifted[pcgdm_pkg::SHIFT_W-1:VW-1];

  always_comb begin
    if (&top || ~|top) begin
      sat = shifted[VW-1:0];
    end else begin
      sat = {shifted[pcgdm_pkg::SHIFT_W-1], {(VW-1){~shifted[pcgdm_pkg::SHIFT_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= valid1_r;
    end
    if (adv_out && valid1_r) begin
      keep_r   <= keep;
      scaled_r <= keep ? sat : '0;
      word_r   <= word;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_tdata   = pcgdm_pkg::OUT_TDATA_W'({word_r, scaled_r});
  assign out_tuser   = keep_r;

  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_addr == pcgdm_pkg::CFG_SEED || cfg_addr == pcgdm_pkg::CFG_STREAM)
    |=> !in_tready ##1 !in_tready)
    else $error("input not stalled during reseed recompute");

  a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(gen_state_r))
    else $error("generator advanced without an accepted beat");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> valid1_r)
    else $error("accepted beat lost before output stage");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> scaled_r == '0)
    else $error("dropped element carries nonzero value");

endmodule
